// File: sv/hexb64_pkg.sv
// ----------------------------------------------------------------------------
// hexb64_pkg
// Shared types, character constants and the Base64 alphabet map.
// ----------------------------------------------------------------------------
package hexb64_pkg;

  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_D0    = 8'h30;  // '0'
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [5:0] SX_UPPER_END = 6'd26;
  localparam logic [5:0] SX_LOWER_END = 6'd52;
  localparam logic [5:0] SX_DIGIT_END = 6'd62;

  localparam logic [2:0] NIB_LAST = 3'd5;

  // One unit of work for the emitter.
  typedef struct packed {
    logic        is_err;
    logic        flush;
    logic [1:0]  pads;
    logic [23:0] bits;
  } job_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] ch;
    if (v < SX_UPPER_END)      ch = CH_UA + {2'b00, v};
    else if (v < SX_LOWER_END) ch = CH_LA + {2'b00, v - SX_UPPER_END};
    else if (v < SX_DIGIT_END) ch = CH_D0 + {2'b00, v - SX_LOWER_END};
    else if (v == SX_DIGIT_END) ch = CH_PLUS;
    else                        ch = CH_SLASH;
    return ch;
  endfunction

endpackage

// File: sv/hexb64_front.sv
// ----------------------------------------------------------------------------
// hexb64_front
// Classifies input words, packs hex nibbles and issues emitter jobs.
// ----------------------------------------------------------------------------
module hexb64_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic              kind,
  input  logic [7:0]        char_code,
  output logic              job_push,
  output hexb64_pkg::job_t  job
);
  import hexb64_pkg::*;

  logic [23:0] group_r, group_nxt;
  logic [2:0]  nib_r, nib_nxt;
  logic        is_space, is_hex;
  logic [3:0]  hval;
  logic [23:0] grp_ins;

  always_comb begin
    is_space = (char_code == 8'h20) || (char_code >= 8'h09 && char_code <= 8'h0D);
    is_hex   = 1'b1;
    hval     = 4'd0;
    if (char_code >= 8'h30 && char_code <= 8'h39) begin
      hval = char_code[3:0];
    end else if ((char_code >= 8'h61 && char_code <= 8'h66) ||
                 (char_code >= 8'h41 && char_code <= 8'h46)) begin
      hval = char_code[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  assign grp_ins = group_r | ({20'd0, hval} << (5'd20 - {nib_r, 2'b00}));

  always_comb begin
    group_nxt    = group_r;
    nib_nxt      = nib_r;
    job_push     = 1'b0;
    job.is_err   = 1'b0;
    job.flush    = 1'b0;
    job.pads     = 2'd0;
    job.bits     = group_r;
    if (acc) begin
      if (kind) begin
        if (nib_r != 3'd0) begin
          job_push  = 1'b1;
          job.flush = 1'b1;
          job.pads  = (nib_r <= 3'd2) ? 2'd2 : 2'd1;
          group_nxt = '0;
          nib_nxt   = '0;
        end
      end else if (!is_space) begin
        if (!is_hex) begin
          job_push   = 1'b1;
          job.is_err = 1'b1;
          group_nxt  = '0;
          nib_nxt    = '0;
        end else if (nib_r == NIB_LAST) begin
          job_push  = 1'b1;
          job.bits  = grp_ins;
          group_nxt = '0;
          nib_nxt   = '0;
        end else begin
          group_nxt = grp_ins;
          nib_nxt   = nib_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r <= '0;
      nib_r   <= '0;
    end else begin
      group_r <= group_nxt;
      nib_r   <= nib_nxt;
    end
  end

endmodule

// File: sv/hexb64_jobq.sv
// ----------------------------------------------------------------------------
// hexb64_jobq
// Small register queue of jobs between the front and the emitter.
// ----------------------------------------------------------------------------
module hexb64_jobq #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hexb64_pkg::job_t  wdata,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output hexb64_pkg::job_t  rdata
);
  import hexb64_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_r];
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_wr) wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    if (do_rd) rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    else if (!do_wr && do_rd) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: sv/hexb64_back.sv
// ----------------------------------------------------------------------------
// hexb64_back
// Emitter: walks a job one character per cycle into the output register, while that register is empty or popped.
// ----------------------------------------------------------------------------
module hexb64_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  hexb64_pkg::job_t  q_job,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [7:0]        out_char,
  output logic              out_last,
  output logic              out_flush,
  output logic              out_bad
);
  import hexb64_pkg::*;

  job_t       job_r;
  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] ch_r;
  logic       last_r, flush_r, bad_r;
  logic       adv, fin;
  logic [5:0] sx;
  logic [7:0] ch_c;
  logic [2:0] padsum;

  assign adv = busy_r && (!ov_r || out_pop);
  assign fin = job_r.is_err || (idx_r == 2'd3);
  assign q_pop = !q_empty && (!busy_r || (adv && fin));

  always_comb begin
    case (idx_r)
      2'd0:    sx = job_r.bits[23:18];
      2'd1:    sx = job_r.bits[17:12];
      2'd2:    sx = job_r.bits[11:6];
      default: sx = job_r.bits[5:0];
    endcase
    padsum = {1'b0, idx_r} + {1'b0, job_r.pads};
    if (job_r.is_err)          ch_c = CH_NUL;
    else if (padsum >= 3'd4)   ch_c = CH_EQ;
    else                       ch_c = sextet_char(sx);
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    ov_nxt   = ov_r && !out_pop;
    if (adv) begin
      ov_nxt  = 1'b1;
      idx_nxt = idx_r + 2'd1;
      if (fin) busy_nxt = 1'b0;
    end
    if (q_pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_job;
    if (adv) begin
      ch_r    <= ch_c;
      last_r  <= fin;
      flush_r <= job_r.flush;
      bad_r   <= job_r.is_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      ov_r   <= ov_nxt;
    end
  end

  assign out_empty = !ov_r;
  assign out_char  = ch_r;
  assign out_last  = last_r;
  assign out_flush = flush_r;
  assign out_bad   = bad_r;

endmodule

// File: sv/hex_text_to_base64_encoder.sv
// ----------------------------------------------------------------------------
// hex_text_to_base64_encoder
// Hex text in, standard Base64 characters out.
// ----------------------------------------------------------------------------
// Input channel: push/full. A word is a hex character (kind 0) or an
// end-of-text marker (kind 1). Whitespace is dropped, a non-hex byte gives
// one word with bad_input set and clears the partial group.
// Output channel: empty/pop. Every sixth hex digit, or a flush of a partial
// group, gives four characters; last_of_group marks the fourth.
// Throughput: one input word per cycle into the packer while full is low;
// the emitter puts out one character per cycle while its output word is
// empty or being popped. Flush or error bursts can outrun the emitter; the
// job queue then fills and full is raised.
// A word that closes a group is written to the job queue at its acceptance
// edge; its first character then passes the emitter's job register and the
// output register before it shows on the output.
// Reset clears the partial group, the job queue and the output register.
// A stalled receiver holds the output word; the emitter and then the job
// queue back up before the input side stalls.
// ----------------------------------------------------------------------------
module hex_text_to_base64_encoder #(
  parameter int JOBQ_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_kind,
  input  logic [7:0] in_char_code,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_char,
  output logic       out_last_of_group,
  output logic       out_from_flush,
  output logic       out_bad_input
);
  import hexb64_pkg::*;

  logic acc, job_push, q_empty, q_pop;
  job_t job_in, job_out;

  assign acc = in_push && !in_full;

  hexb64_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .kind      (in_kind),
    .char_code (in_char_code),
    .job_push  (job_push),
    .job       (job_in)
  );

  hexb64_jobq #(.DEPTH(JOBQ_DEPTH)) u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_in),
    .full  (in_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (job_out)
  );

  hexb64_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (job_out),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_char  (out_char),
    .out_last  (out_last_of_group),
    .out_flush (out_from_flush),
    .out_bad   (out_bad_input)
  );

endmodule

// File: sv/hexb64_checker.sv
// ----------------------------------------------------------------------------
// hexb64_checker
// Port-level checks on the encoder's output stream, bound to the top level.
// ----------------------------------------------------------------------------
module hexb64_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_char,
  input logic       out_last_of_group,
  input logic       out_from_flush,
  input logic       out_bad_input
);
  import hexb64_pkg::*;

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("output not empty after reset");

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_bad_input) |->
      (out_char == CH_NUL && out_last_of_group && !out_from_flush))
    else $error("malformed error word");

  a_pad_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && out_char == CH_EQ && !out_last_of_group) |=>
      (!out_empty && out_char == CH_EQ))
    else $error("padding not carried to end of group");

  a_flush_pad: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_from_flush && out_last_of_group) |-> (out_char == CH_EQ))
    else $error("flushed group without padding");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_char)))
    else $error("stalled output word changed");

endmodule

bind hex_text_to_base64_encoder hexb64_checker u_hexb64_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_empty         (out_empty),
  .out_pop           (out_pop),
  .out_char          (out_char),
  .out_last_of_group (out_last_of_group),
  .out_from_flush    (out_from_flush),
  .out_bad_input     (out_bad_input)
);

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Test bench for the hex text to Base64 encoder.
// Hex digits, whitespace, bad bytes and end-of-text words go in through the
// push/full side under random gaps. Every accepted word is run through a
// local Base64 packer, and each popped character is matched field by field
// against the oldest one it predicts. One phase stalls the reader long
// enough to back the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;
  import hexb64_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOT  = 1'b1;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       flush;
    logic       bad;
  } b64_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic       in_kind = 1'b0;
  logic [7:0] in_char_code = 8'h00;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [7:0] out_char;
  logic       out_last_of_group;
  logic       out_from_flush;
  logic       out_bad_input;

  b64_word_t   b64_chars_due[$];
  logic [23:0] grp_bits = 24'h0;
  logic [2:0]  nib_cnt = 3'd0;
  int          err_cnt = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_cnt = 0;
  int          rx_gap = 0;

  hex_text_to_base64_encoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_kind           (in_kind),
    .in_char_code      (in_char_code),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_char          (out_char),
    .out_last_of_group (out_last_of_group),
    .out_from_flush    (out_from_flush),
    .out_bad_input     (out_bad_input)
  );

  always #6 clk = ~clk;

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] sextet_to_char(input logic [5:0] sx);
    if (sx < 6'd26) return "A" + sx;
    if (sx < 6'd52) return "a" + (sx - 6'd26);
    if (sx < 6'd62) return "0" + (sx - 6'd52);
    if (sx == 6'd62) return "+";
    return "/";
  endfunction

  task automatic emit_quad(input int pads, input logic flush);
    int        k;
    logic [5:0] sx;
    b64_word_t w;
    for (k = 0; k < 4; k++) begin
      sx = 6'(grp_bits >> (18 - 6 * k));
      w.ch = (k >= 4 - pads) ? CH_EQ : sextet_to_char(sx);
      w.last = (k == 3);
      w.flush = flush;
      w.bad = 1'b0;
      b64_chars_due.push_back(w);
    end
    grp_bits = 24'h0;
    nib_cnt = 3'd0;
  endtask

  task automatic encode_word(input logic kind, input logic [7:0] code);
    logic [3:0] nib;
    logic       is_hex;
    b64_word_t  w;
    is_hex = 1'b1;
    nib = 4'h0;
    if (code >= "0" && code <= "9") nib = 4'(code - "0");
    else if (code >= "a" && code <= "f") nib = 4'(code - "a" + 8'd10);
    else if (code >= "A" && code <= "F") nib = 4'(code - "A" + 8'd10);
    else is_hex = 1'b0;
    if (kind == KIND_EOT) begin
      if (nib_cnt != 3'd0) emit_quad((nib_cnt <= 3'd2) ? 2 : 1, 1'b1);
    end else if (code == 8'h20 || (code >= 8'h09 && code <= 8'h0D)) begin
      // whitespace: dropped
    end else if (!is_hex) begin
      grp_bits = 24'h0;
      nib_cnt = 3'd0;
      w.ch = CH_NUL;
      w.last = 1'b1;
      w.flush = 1'b0;
      w.bad = 1'b1;
      b64_chars_due.push_back(w);
    end else begin
      grp_bits[(23 - 4 * int'(nib_cnt)) -: 4] = nib;
      nib_cnt = nib_cnt + 3'd1;
      if (nib_cnt == 3'd6) emit_quad(0, 1'b0);
    end
  endtask

  task automatic send_word(input logic kind, input logic [7:0] code);
    int gap;
    in_push <= 1'b1;
    in_kind <= kind;
    in_char_code <= code;
    @(posedge clk);
    while (in_full) @(posedge clk);
    encode_word(kind, code);
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    in_push <= 1'b0;
    while (b64_chars_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_hex_digit();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'("0" + v);
    if ($urandom_range(0, 1) == 0) return 8'("a" + v - 10);
    return 8'("A" + v - 10);
  endfunction

  function automatic logic [7:0] rand_blank();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return 8'h20;
    return 8'(8'h08 + r);
  endfunction

  task automatic check_word();
    b64_word_t w;
    if (b64_chars_due.size() == 0) begin
      $display("%0t: unexpected word char=%h last=%b flush=%b bad=%b", $time,
               out_char, out_last_of_group, out_from_flush, out_bad_input);
      err_cnt++;
    end else begin
      w = b64_chars_due.pop_front();
      if (out_char !== w.ch) begin
        $display("%0t: out_char expected %h actual %h", $time, w.ch, out_char);
        err_cnt++;
      end
      if (out_last_of_group !== w.last) begin
        $display("%0t: out_last_of_group expected %b actual %b", $time, w.last,
                 out_last_of_group);
        err_cnt++;
      end
      if (out_from_flush !== w.flush) begin
        $display("%0t: out_from_flush expected %b actual %b", $time, w.flush,
                 out_from_flush);
        err_cnt++;
      end
      if (out_bad_input !== w.bad) begin
        $display("%0t: out_bad_input expected %b actual %b", $time, w.bad,
                 out_bad_input);
        err_cnt++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        check_word();
        rx_gap = pick_gap(rx_calm);
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_pop <= 1'b0;
      end else if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_cnt = HOLD_CYCLES;
        out_pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet = 0;
      else quiet++;
    end
    $display("tb_top: errors");
    $finish;
  end

  task automatic test_directed();
    send_word(KIND_CHAR, "0");
    send_word(KIND_CHAR, "9");
    send_word(KIND_CHAR, "a");
    send_word(KIND_CHAR, "f");
    send_word(KIND_CHAR, "A");
    send_word(KIND_CHAR, "F");
    send_word(KIND_EOT, 8'hFF);
    send_word(KIND_CHAR, "F");
    send_word(KIND_EOT, 8'h00);
    send_word(KIND_CHAR, "f");
    send_word(KIND_CHAR, 8'h20);
    send_word(KIND_CHAR, 8'h09);
    send_word(KIND_CHAR, "f");
    send_word(KIND_CHAR, 8'h0D);
    send_word(KIND_CHAR, "f");
    send_word(KIND_CHAR, 8'h00);
    send_word(KIND_CHAR, 8'hFF);
    send_word(KIND_CHAR, "e");
    send_word(KIND_CHAR, "E");
    send_word(KIND_CHAR, "d");
    send_word(KIND_CHAR, "D");
    send_word(KIND_CHAR, "c");
    send_word(KIND_EOT, "g");
  endtask

  task automatic test_random_stream(input int count);
    int i;
    int r;
    for (i = 0; i < count; i++) begin
      tx_calm = (i >= 25 && i < 40);
      rx_calm = tx_calm;
      r = $urandom_range(0, 99);
      if (r < 68) send_word(KIND_CHAR, rand_hex_digit());
      else if (r < 76) send_word(KIND_CHAR, rand_blank());
      else if (r < 86) send_word(KIND_EOT, 8'($urandom_range(0, 255)));
      else send_word(KIND_CHAR, 8'($urandom_range(0, 255)));
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  task automatic test_backpressure();
    int i;
    hold_req <= hold_req + 1;
    @(posedge clk);
    while (hold_seen != hold_req) @(posedge clk);
    tx_calm = 1'b1;
    for (i = 0; i < 36; i++) begin
      if (i % 3 == 2) send_word(KIND_CHAR, "x");
      else send_word(KIND_CHAR, rand_hex_digit());
    end
    send_word(KIND_EOT, 8'h00);
    tx_calm = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_drain();
    test_random_stream(60);
    wait_drain();
    test_backpressure();
    wait_drain();
    repeat (10) @(posedge clk);
    if (err_cnt == 0 && b64_chars_due.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
